// File: rtl/bblur_pkg.sv
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared types and constants of the 3x3 box blur with border keep.
// ----------------------------------------------------------------------------
`default_nettype none

package bblur_pkg;

    localparam int PIX_W      = 8;
    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int SUM_W      = 12;

    localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 11'd800;
    localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = 13'd600;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // floor(s / 9) == (s * 7282) >> 16 for every s below 32768
    localparam int DIV9_MUL_W = 13;
    localparam int DIV9_SHIFT = 16;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;

    typedef struct packed {
        logic             filler;
        logic [PIX_W-1:0] pixel_in;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } pix_out_t;

endpackage

`default_nettype wire

// File: rtl/bblur_ram.sv
// ----------------------------------------------------------------------------
// bblur_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bblur_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/box_blur_3x3_border_keep.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_border_keep
// Streaming 3x3 mean filter; border rows and columns pass through unchanged.
// ----------------------------------------------------------------------------
//  channel  | signals                         | beat
//  ---------+---------------------------------+-------------------------------
//  in       | in_valid, in_ready, in_data     | filler flag + raster pixel
//  out      | out_valid, out_ready, out_data  | result pixel + frame_end
//  cfg      | cfg_we, cfg_index, cfg_data     | register write, no read-back
//
//  One beat per cycle in and out while nothing stalls; a result passes the
//  stage 1, stage 2 and output registers after the beat that completes its
//  window, and matches the pixel taken width+1 beats before. After reset a
//  clearing pass zeroes both line stores; in_ready stays low during it.
//  in_ready is low in the cycle of a cfg write and the cycle after it.
//  out_ready low stalls the three-stage pipe back to the input.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_border_keep #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire bblur_pkg::pix_in_t                   in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output bblur_pkg::pix_out_t                       out_data,
    input  wire logic                                 cfg_we,
    input  wire logic [bblur_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bblur_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import bblur_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int IW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);

    // configuration
    logic [IMG_W_BITS-1:0] img_w_reg;
    logic [IMG_H_BITS-1:0] img_h_reg;
    logic                  settle_reg;
    logic [WW-1:0]         eff_w;
    logic [RW-1:0]         eff_h;
    logic [WW-1:0]         w_reg;
    logic [WW-1:0]         wm1_reg;
    logic [RW-1:0]         hm1_reg;
    logic [IW-1:0]         pixels_reg;
    logic [IW-1:0]         last_idx_reg;

    // clearing pass
    logic                  clr_active_reg;
    logic [CW-1:0]         clr_cnt_reg;

    // position counters
    logic [IW-1:0]         items_reg;
    logic [CW-1:0]         in_col_reg;
    logic [CW-1:0]         out_col_reg;
    logic [RW-1:0]         out_row_reg;

    // stage 1: line store read
    logic                  s1_valid_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [PIX_W-1:0]      s1_v_reg;
    logic                  s1_prod_reg;
    logic                  s1_border_reg;
    logic                  s1_last_reg;
    logic                  s1_fwd_reg;
    logic [PIX_W-1:0]      s1_fwd_up_reg;
    logic [PIX_W-1:0]      s1_fwd_mid_reg;

    // stage 2: window sum
    logic                  s2_valid_reg;
    logic [SUM_W-1:0]      s2_sum_reg;
    logic [PIX_W-1:0]      s2_center_reg;
    logic                  s2_border_reg;
    logic                  s2_last_reg;

    // output register
    logic                  out_valid_reg;
    pix_out_t              out_data_reg;

    logic [PIX_W-1:0]      win_reg [0:2][0:2];

    // memory ports
    logic                  ram_we;
    logic [CW-1:0]         ram_waddr;
    logic [PIX_W-1:0]      up_wdata;
    logic [PIX_W-1:0]      mid_wdata;
    logic [PIX_W-1:0]      up_rdata;
    logic [PIX_W-1:0]      mid_rdata;

    // control
    logic                  in_fire;
    logic                  upd;
    logic                  pix_phase;
    logic [PIX_W-1:0]      in_v;
    logic                  in_prod;
    logic                  in_border;
    logic                  in_last;
    logic                  fwd_hit;
    logic                  out_load;
    logic                  s2_en;
    logic                  s1_adv;
    logic                  s1_en;
    logic [PIX_W-1:0]      up_rd;
    logic [PIX_W-1:0]      mid_rd;
    logic [SUM_W-1:0]      win_sum;
    logic [SUM_W+DIV9_MUL_W-1:0] prod_div;
    logic [PIX_W-1:0]      mean;

    logic [WW-1:0]         in_col_inc;
    logic [WW-1:0]         out_col_inc;
    logic [CW-1:0]         in_col_next;
    logic [CW-1:0]         out_col_next;
    logic [RW-1:0]         out_row_next;
    logic [IW-1:0]         items_next;

    // ------------------------------------------------------------------
    // configuration registers and derived frame limits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg  <= IMG_W_RESET;
            img_h_reg  <= IMG_H_RESET;
            settle_reg <= 1'b1;
        end
        else
        begin
            settle_reg <= cfg_we;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  img_w_reg <= cfg_data[IMG_W_BITS-1:0];
                    REG_IMAGE_HEIGHT: img_h_reg <= cfg_data[IMG_H_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        if (img_w_reg == '0)
            eff_w = WW'(1);
        else if (32'(img_w_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(img_w_reg);

        if (img_h_reg == '0)
            eff_h = RW'(1);
        else if (32'(img_h_reg) > MAX_HEIGHT)
            eff_h = RW'(MAX_HEIGHT);
        else
            eff_h = RW'(img_h_reg);
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= eff_w;
        wm1_reg      <= eff_w - WW'(1);
        hm1_reg      <= eff_h - RW'(1);
        pixels_reg   <= IW'(eff_w) * IW'(eff_h);
        last_idx_reg <= IW'(eff_w) * IW'(eff_h) + IW'(eff_w);
    end

    // ------------------------------------------------------------------
    // handshake and pipe control
    // ------------------------------------------------------------------
    assign out_load = s2_valid_reg & (~out_valid_reg | out_ready);
    assign s2_en    = ~s2_valid_reg | out_load;
    assign s1_adv   = s1_valid_reg & s2_en;
    assign s1_en    = ~s1_valid_reg | s1_adv;
    assign in_ready = s1_en & ~clr_active_reg & ~settle_reg & ~cfg_we;
    assign in_fire  = in_valid & in_ready;

    // ------------------------------------------------------------------
    // stage 0: classify beat, advance positions, issue line store read
    // ------------------------------------------------------------------
    assign pix_phase = items_reg < pixels_reg;
    assign upd       = in_fire & ~(pix_phase & in_data.filler);
    assign in_v      = pix_phase ? in_data.pixel_in : '0;
    assign in_prod   = items_reg > IW'(w_reg);
    assign in_last   = items_reg >= last_idx_reg;
    assign in_border = (out_row_reg == '0) || (out_row_reg >= RW'(hm1_reg)) ||
                       (out_col_reg == '0) || (WW'(out_col_reg) >= wm1_reg);
    assign fwd_hit   = s1_adv & (s1_col_reg == in_col_reg);

    always_comb
    begin
        in_col_inc  = WW'(in_col_reg) + WW'(1);
        out_col_inc = WW'(out_col_reg) + WW'(1);
        in_col_next = (in_col_inc >= w_reg) ? '0 : CW'(in_col_inc);
        if (out_col_inc >= w_reg)
        begin
            out_col_next = '0;
            out_row_next = (out_row_reg == RW'(MAX_HEIGHT)) ? out_row_reg
                                                            : out_row_reg + RW'(1);
        end
        else
        begin
            out_col_next = CW'(out_col_inc);
            out_row_next = out_row_reg;
        end
        items_next = items_reg + IW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_reg   <= '0;
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (upd)
        begin
            if (in_last)
            begin
                items_reg   <= '0;
                in_col_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else
            begin
                items_reg  <= items_next;
                in_col_reg <= in_col_next;
                if (in_prod)
                begin
                    out_col_reg <= out_col_next;
                    out_row_reg <= out_row_next;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // clearing pass over the line stores
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_cnt_reg == CW'(MAX_WIDTH - 1))
                clr_active_reg <= 1'b0;
            else
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
        end
    end

    // ------------------------------------------------------------------
    // stage 1: window shift and line store write-back
    // ------------------------------------------------------------------
    assign up_rd  = s1_fwd_reg ? s1_fwd_up_reg  : up_rdata;
    assign mid_rd = s1_fwd_reg ? s1_fwd_mid_reg : mid_rdata;

    assign ram_we    = clr_active_reg | s1_adv;
    assign ram_waddr = clr_active_reg ? clr_cnt_reg : s1_col_reg;
    assign up_wdata  = clr_active_reg ? '0 : mid_rd;
    assign mid_wdata = clr_active_reg ? '0 : s1_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_en)
            s1_valid_reg <= upd;
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            s1_col_reg     <= in_col_reg;
            s1_v_reg       <= in_v;
            s1_prod_reg    <= in_prod;
            s1_border_reg  <= in_border;
            s1_last_reg    <= in_last;
            s1_fwd_reg     <= fwd_hit;
            s1_fwd_up_reg  <= mid_rd;
            s1_fwd_mid_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (s1_adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= up_rd;
            win_reg[1][2] <= mid_rd;
            win_reg[2][2] <= s1_v_reg;
        end
    end

    assign win_sum = SUM_W'(win_reg[0][1]) + SUM_W'(win_reg[0][2]) +
                     SUM_W'(win_reg[1][1]) + SUM_W'(win_reg[1][2]) +
                     SUM_W'(win_reg[2][1]) + SUM_W'(win_reg[2][2]) +
                     SUM_W'(up_rd) + SUM_W'(mid_rd) + SUM_W'(s1_v_reg);

    // ------------------------------------------------------------------
    // stage 2: divide by nine, pick border or mean
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_en)
            s2_valid_reg <= s1_adv & s1_prod_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_sum_reg    <= win_sum;
            s2_center_reg <= win_reg[1][2];
            s2_border_reg <= s1_border_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    assign prod_div = (SUM_W + DIV9_MUL_W)'(s2_sum_reg) *
                      (SUM_W + DIV9_MUL_W)'(DIV9_MUL);
    assign mean     = prod_div[DIV9_SHIFT +: PIX_W];

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.pixel_out <= s2_border_reg ? s2_center_reg : mean;
            out_data_reg.frame_end <= s2_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // line stores
    // ------------------------------------------------------------------
    bblur_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_upper_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (up_wdata),
        .re    (upd),
        .raddr (in_col_reg),
        .rdata (up_rdata)
    );

    bblur_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_middle_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (mid_wdata),
        .re    (upd),
        .raddr (in_col_reg),
        .rdata (mid_rdata)
    );

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !in_ready)
        else $error("beat accepted during line store clear");

    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cfg_we) |-> !in_ready)
        else $error("beat accepted before frame limits settled");

    a_s1_drains_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s1_valid_reg) |-> s1_adv)
        else $error("stage 1 overwritten while stalled");

    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !out_load) |=> s2_valid_reg)
        else $error("stage 2 result dropped");

endmodule

`default_nettype wire
